// ===== rtl/gslp_pkg.sv =====
// Package for the gated sustain-loop phase core: widths, commands, field layout.
package gslp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 32;
  localparam int BND_W     = INT_BITS + FRAC_BITS;
  localparam int PH_W      = BND_W + 2;
  localparam int STEP_W    = 32;
  localparam int CMD_W     = 2;
  localparam int DIV_W     = PH_W + 1;
  localparam int CNT_W     = $clog2(DIV_W);

  localparam int IN_BITS   = 1 + STEP_W + 3 * BND_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((PH_W + 7) / 8) * 8;

  localparam int GATE_LSB  = 0;
  localparam int STEP_LSB  = GATE_LSB + 1;
  localparam int LO_LSB    = STEP_LSB + STEP_W;
  localparam int HI_LSB    = LO_LSB + BND_W;
  localparam int LIM_LSB   = HI_LSB + BND_W;

  localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP    = 2'd2;

  typedef logic [BND_W-1:0]        bnd_t;
  typedef logic signed [PH_W-1:0]  ph_t;
  typedef logic signed [STEP_W-1:0] step_t;

endpackage

// ===== rtl/gated_sustain_loop_phase_core.sv =====
// Top level: gated sustain-loop phase core with a bit-serial wrap remainder unit.
//
//   channel | ports                                  | moves
//   --------+----------------------------------------+------------------------------
//   input   | in_tvalid in_tready in_tdata in_tuser  | command + gate, step, bounds
//   output  | out_tvalid out_tready out_tdata        | phase_out, one per sample item
//
// A sample item passes S_IDLE, S_ORD and S_POST (equal bounds or not looping), adds S_CMP
// when looping without a wrap, and S_DIV and S_FIX when the phase wraps: the wrap remainder
// runs a restoring shift-subtract over 51 dividend bits, one bit per cycle.
// Restart and stop items are taken in S_IDLE and give no result.
// Reset (rst_n low, synchronous) clears phase, gate history and running; looping is set.
// A new item is taken while the last result still waits; the final cycle of an
// item holds until the output register is free.
module gated_sustain_loop_phase_core
  import gslp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] gate, [32:1] step, [80:33] loop_begin, [128:81] loop_finish,
  // [176:129] phase_limit, rest zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] cmd
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [49:0] phase_out, rest zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ORD  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;
  localparam logic [2:0] S_POST = 3'd5;

  logic [2:0]       state_r, state_nxt;
  ph_t              phase_acc_r, phase_acc_nxt;
  logic             gate_prev_r, gate_prev_nxt;
  logic             looping_r, looping_nxt;
  logic             running_r, running_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  ph_t              ph_r, ph_nxt;
  step_t            step_r, step_nxt;
  bnd_t             lo_r, lo_nxt;
  bnd_t             hi_r, hi_nxt;
  bnd_t             lim_r, lim_nxt;
  bnd_t             s_r, s_nxt;
  bnd_t             e_r, e_nxt;
  bnd_t             range_r, range_nxt;
  logic             wrap_neg_r, wrap_neg_nxt;
  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  bnd_t             rem_r, rem_nxt;
  ph_t              out_data_r, out_data_nxt;

  logic             in_gate;
  step_t            in_step;
  bnd_t             in_lo, in_hi, in_lim;
  logic             accept;
  logic             step_neg, step_pos;
  bnd_t             s_ord, e_ord;
  bnd_t             range_c;
  logic             below_s, above_e;
  logic [BND_W:0]   trial;
  logic [BND_W:0]   trial_sub;
  logic [PH_W:0]    adv_sum;
  logic             out_free;

  assign in_gate = in_tdata[GATE_LSB];
  assign in_step = in_tdata[STEP_LSB +: STEP_W];
  assign in_lo   = in_tdata[LO_LSB +: BND_W];
  assign in_hi   = in_tdata[HI_LSB +: BND_W];
  assign in_lim  = in_tdata[LIM_LSB +: BND_W];

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - PH_W){1'b0}}, out_data_r};
  assign out_free   = !out_valid_r || out_tready;

  assign step_neg = step_r[STEP_W-1];
  assign step_pos = !step_r[STEP_W-1] && (|step_r);

  assign s_ord   = (lo_r < hi_r) ? lo_r : hi_r;
  assign e_ord   = (lo_r < hi_r) ? hi_r : lo_r;
  assign range_c = e_r - s_r;
  assign below_s = ph_r < $signed({2'b00, s_r});
  assign above_e = ph_r > $signed({2'b00, e_r});

  assign trial     = {rem_r, dvd_r[DIV_W-1]};
  assign trial_sub = trial - {1'b0, range_r};

  assign adv_sum = {ph_r[PH_W-1], ph_r} + {{(PH_W + 1 - STEP_W){step_r[STEP_W-1]}}, step_r};

  always_comb begin
    state_nxt     = state_r;
    phase_acc_nxt = phase_acc_r;
    gate_prev_nxt = gate_prev_r;
    looping_nxt   = looping_r;
    running_nxt   = running_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    ph_nxt        = ph_r;
    step_nxt      = step_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    lim_nxt       = lim_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    range_nxt     = range_r;
    wrap_neg_nxt  = wrap_neg_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          step_nxt = in_step;
          lo_nxt   = in_lo;
          hi_nxt   = in_hi;
          lim_nxt  = in_lim;
          unique case (in_tuser)
            CMD_RESTART: begin
              phase_acc_nxt = '0;
              running_nxt   = 1'b1;
              looping_nxt   = 1'b1;
            end
            CMD_STOP: begin
              phase_acc_nxt = '0;
              running_nxt   = 1'b0;
            end
            CMD_SAMPLE: begin
              ph_nxt        = phase_acc_r;
              gate_prev_nxt = in_gate;
              if (in_gate && !gate_prev_r) begin
                if (!in_step[STEP_W-1] && (|in_step)) begin
                  ph_nxt = '0;
                end else if (in_step[STEP_W-1]) begin
                  ph_nxt = $signed({2'b00, in_lim});
                end
                running_nxt = 1'b1;
                looping_nxt = 1'b1;
              end else if (!in_gate && gate_prev_r) begin
                looping_nxt = 1'b0;
              end
              state_nxt = S_ORD;
            end
            default: ;
          endcase
        end
      end
      S_ORD: begin
        if (looping_r) begin
          if (lo_r == hi_r) begin
            ph_nxt    = $signed({2'b00, lo_r});
            state_nxt = S_POST;
          end else begin
            s_nxt     = (s_ord > lim_r) ? lim_r : s_ord;
            e_nxt     = (e_ord > lim_r) ? lim_r : e_ord;
            state_nxt = S_CMP;
          end
        end else begin
          if (ph_r[PH_W-1] && step_neg) begin
            ph_nxt      = $signed({2'b00, lim_r});
            running_nxt = 1'b0;
          end else if (ph_r > $signed({2'b00, lim_r}) && step_pos) begin
            ph_nxt      = '0;
            running_nxt = 1'b0;
          end
          state_nxt = S_POST;
        end
      end
      S_CMP: begin
        range_nxt    = range_c;
        wrap_neg_nxt = below_s && step_neg;
        rem_nxt      = '0;
        cnt_nxt      = '0;
        state_nxt    = S_POST;
        if ((below_s && step_neg) || (above_e && step_pos)) begin
          if (range_c == '0) begin
            ph_nxt = $signed({2'b00, s_r});
          end else begin
            if (below_s && step_neg) begin
              dvd_nxt = {3'b000, s_r} - {ph_r[PH_W-1], ph_r};
            end else begin
              dvd_nxt = {ph_r[PH_W-1], ph_r} - {3'b000, s_r};
            end
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt = (trial >= {1'b0, range_r}) ? trial_sub[BND_W-1:0] : trial[BND_W-1:0];
        dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        if (wrap_neg_r) begin
          ph_nxt = (rem_r == '0) ? $signed({2'b00, s_r}) : $signed({2'b00, e_r - rem_r});
        end else begin
          ph_nxt = $signed({2'b00, s_r + rem_r});
        end
        state_nxt = S_POST;
      end
      S_POST: begin
        if (out_free) begin
          out_data_nxt  = ph_r;
          out_valid_nxt = 1'b1;
          if (!running_r) begin
            phase_acc_nxt = ph_r;
          end else if (adv_sum[PH_W] != adv_sum[PH_W-1]) begin
            phase_acc_nxt = adv_sum[PH_W] ? {1'b1, {(PH_W-1){1'b0}}} : {1'b0, {(PH_W-1){1'b1}}};
          end else begin
            phase_acc_nxt = adv_sum[PH_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_acc_r <= '0;
      gate_prev_r <= 1'b0;
      looping_r   <= 1'b1;
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_acc_r <= phase_acc_nxt;
      gate_prev_r <= gate_prev_nxt;
      looping_r   <= looping_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r       <= ph_nxt;
    step_r     <= step_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    lim_r      <= lim_nxt;
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    range_r    <= range_nxt;
    wrap_neg_r <= wrap_neg_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/gslp_checker.sv =====
// Port-level checker for the gated sustain-loop phase core, bound to the top level.
module gslp_checker
  import gslp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [CMD_W-1:0]      in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_SAMPLE |=> !in_tready)
    else $error("sample item did not occupy the core");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a sample in flight");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:PH_W] == '0)
    else $error("result padding bits not zero");

endmodule

bind gated_sustain_loop_phase_core gslp_checker u_gslp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// ===== sim/gated_sustain_loop_phase_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for gated_sustain_loop_phase_core: predicts each phase and checks it.
module gated_sustain_loop_phase_core_test;
  import gslp_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int DRAIN_CYCLES    = 80;
  localparam int ITEMS_PER_PHASE = 100;
  localparam longint PH_MAX_L = (longint'(1) <<< (PH_W - 1)) - 1;
  localparam longint PH_MIN_L = -PH_MAX_L - 1;
  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

  class phase_tracker;
    ph_t expected_phase[$];
    ph_t phase_acc;
    bit  gate_prev;
    bit  looping;
    bit  running;
    int  errors;

    function new();
      phase_acc = '0;
      gate_prev = 1'b0;
      looping   = 1'b1;
      running   = 1'b0;
      errors    = 0;
    endfunction

    function void take_item(logic [CMD_W-1:0] cmd, logic [IN_DATA_W-1:0] data);
      bit     gate;
      step_t  step_v;
      longint st, lo, hi, lim, ph, s, e, rng, k;
      gate   = data[GATE_LSB];
      step_v = data[STEP_LSB +: STEP_W];
      st     = step_v;
      lo     = data[LO_LSB +: BND_W];
      hi     = data[HI_LSB +: BND_W];
      lim    = data[LIM_LSB +: BND_W];
      ph     = phase_acc;
      if (cmd == CMD_RESTART) begin
        phase_acc = '0;
        running   = 1'b1;
        looping   = 1'b1;
        return;
      end
      if (cmd == CMD_STOP) begin
        phase_acc = '0;
        running   = 1'b0;
        return;
      end
      if (cmd != CMD_SAMPLE) return;

      if (gate && !gate_prev) begin
        if (st > 0) ph = 0;
        else if (st < 0) ph = lim;
        running = 1'b1;
        looping = 1'b1;
      end else if (!gate && gate_prev) begin
        looping = 1'b0;
      end

      if (looping) begin
        if (lo == hi) begin
          ph = lo;
        end else begin
          s = (lo < hi) ? lo : hi;
          e = (lo < hi) ? hi : lo;
          if (e > lim) e = lim;
          if (s > lim) s = lim;
          rng = e - s;
          if (ph < s && st < 0) begin
            if (rng == 0) begin
              ph = s;
            end else begin
              k  = (s - ph + rng - 1) / rng;
              ph = ph + k * rng;
            end
          end else if (ph > e && st > 0) begin
            if (rng == 0) ph = s;
            else ph = s + (ph - s) % rng;
          end
        end
      end else begin
        if (ph < 0 && st < 0) begin
          ph      = lim;
          running = 1'b0;
        end
        if (ph > lim && st > 0) begin
          ph      = 0;
          running = 1'b0;
        end
      end

      expected_phase.push_back(ph_t'(ph));
      gate_prev = gate;
      if (running) begin
        ph = ph + st;
        if (ph > PH_MAX_L) ph = PH_MAX_L;
        else if (ph < PH_MIN_L) ph = PH_MIN_L;
      end
      phase_acc = ph_t'(ph);
    endfunction

    function void check_phase(logic [OUT_DATA_W-1:0] data);
      ph_t got;
      ph_t want;
      got = data[PH_W-1:0];
      if (expected_phase.size() == 0) begin
        errors++;
        $display("%0t: phase_out expected none, actual %0d", $time, got);
        return;
      end
      want = expected_phase.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: phase_out expected %0d, actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [0] gate, [32:1] step, [80:33] loop_begin,
                                          // [128:81] loop_finish, [176:129] phase_limit
  logic [CMD_W-1:0]      in_tuser = '0;   // [1:0] cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [49:0] phase_out

  phase_tracker tracker;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int sent_items = 0;
  int stalled_cycles = 0;

  gated_sustain_loop_phase_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.check_phase(out_tdata);
      if (in_tvalid && in_tready) tracker.take_item(in_tuser, in_tdata);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) stalled_cycles = 0;
      else stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_CYCLES);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic step_t qs(int n);
    return step_t'(longint'(n) <<< FRAC_BITS);
  endfunction

  function automatic bnd_t qb(int n);
    return bnd_t'(longint'(n) <<< FRAC_BITS);
  endfunction

  function automatic bnd_t rand_bnd();
    return bnd_t'({$urandom(), $urandom()});
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(bit gate, step_t st, bnd_t lo, bnd_t hi,
                                                     bnd_t lim);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[GATE_LSB] = gate;
    d[STEP_LSB +: STEP_W] = st;
    d[LO_LSB +: BND_W] = lo;
    d[HI_LSB +: BND_W] = hi;
    d[LIM_LSB +: BND_W] = lim;
    return d;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [IN_DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (cmd != CMD_IGNORED) sent_items++;
  endtask

  task automatic send_sample(bit gate, step_t st, bnd_t lo, bnd_t hi, bnd_t lim);
    send_item(CMD_SAMPLE, pack_item(gate, st, lo, hi, lim));
  endtask

  task automatic send_noise();
    logic [IN_DATA_W-1:0] d;
    d = pack_item(1'($urandom_range(1)), $urandom(), rand_bnd(), rand_bnd(), rand_bnd());
    case ($urandom_range(3))
      0: send_item(CMD_RESTART, d);
      1: send_item(CMD_STOP, d);
      2: send_item(CMD_IGNORED, d);
      default: send_item(CMD_SAMPLE, d);
    endcase
  endtask

  // one note: gate held for two to ten samples, then released for one to six samples
  task automatic random_note();
    bnd_t  lo, hi, lim;
    step_t st;
    int    mag;
    int    held;
    int    released;
    if ($urandom_range(4) == 0) begin
      lim = rand_bnd();
      lo  = rand_bnd();
      hi  = rand_bnd();
      st  = $urandom();
    end else begin
      lim = bnd_t'($urandom_range(1 << 20, 16));
      lo  = bnd_t'($urandom_range(int'(lim) + int'(lim) / 8));
      hi  = bnd_t'($urandom_range(int'(lim) + int'(lim) / 8));
      mag = int'($urandom_range(int'(lim) / 3 + 1, 1));
      st  = $urandom_range(1) ? -mag : mag;
      if ($urandom_range(9) == 0) st = '0;
    end
    if ($urandom_range(9) == 0) hi = lo;
    held     = $urandom_range(10, 2);
    released = $urandom_range(6, 1);
    repeat (held) begin
      if ($urandom_range(11) == 0) send_noise();
      if ($urandom_range(7) == 0) st = -st;
      send_sample(1'b1, st, lo, hi, lim);
    end
    repeat (released) begin
      if ($urandom_range(15) == 0) send_noise();
      send_sample(1'b0, st, lo, hi, lim);
    end
  endtask

  initial begin
    int target;
    tracker = new();
    target = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // equal bounds straight out of reset
    send_sample(1'b0, '0, '0, '0, '0);
    // rising gate, forward step, wrap past loop end
    repeat (4) send_sample(1'b1, qs(7), qb(10), qb(20), qb(100));
    // falling gate, then rising with reverse step and swapped bounds, wrap below start
    send_sample(1'b0, qs(-40), qb(20), qb(10), qb(100));
    repeat (4) send_sample(1'b1, qs(-40), qb(20), qb(10), qb(100));
    // rising gate with zero step keeps the phase
    send_sample(1'b0, '0, qb(10), qb(20), qb(100));
    send_sample(1'b1, '0, qb(10), qb(20), qb(100));
    // restart, then both bounds above the maximum: zero range pins to start
    send_item(CMD_RESTART, pack_item(1'b0, qs(5), qb(1), qb(2), qb(3)));
    repeat (3) send_sample(1'b1, qs(60), qb(150), qb(200), qb(100));
    send_sample(1'b1, qs(-30), qb(200), qb(150), qb(100));
    // stop command, unknown command
    send_item(CMD_STOP, pack_item(1'b1, qs(-5), qb(1), qb(2), qb(3)));
    send_item(CMD_IGNORED, pack_item(1'b1, qs(9), qb(4), qb(8), qb(50)));
    // without looping: run past the maximum, then below zero
    send_sample(1'b0, qs(60), qb(10), qb(20), qb(100));
    send_sample(1'b1, qs(60), qb(10), qb(20), qb(100));
    repeat (3) send_sample(1'b0, qs(60), qb(10), qb(20), qb(100));
    send_sample(1'b1, qs(-60), qb(10), qb(20), qb(100));
    repeat (3) send_sample(1'b0, qs(-60), qb(10), qb(20), qb(100));
    // field extremes
    send_sample(1'b1, 32'h7fff_ffff, '1, '0, '1);
    send_sample(1'b0, 32'h8000_0000, '1, '1, '1);
    send_sample(1'b1, 32'h8000_0000, '0, '1, '1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 57;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 57;
        end
        default: begin
          send_idle_pct = 9;
          stall_pct = 9;
        end
      endcase
      target = sent_items + ITEMS_PER_PHASE;
      while (sent_items < target) random_note();
    end
    in_tvalid <= 1'b0;

    while (tracker.expected_phase.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gslp_pkg.sv
rtl/gated_sustain_loop_phase_core.sv
rtl/gslp_checker.sv
sim/gated_sustain_loop_phase_core_test.sv
